// ===== design/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, codes and constants of the three-level priority thread
// scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

   // Default number of thread ids the scheduler tracks.
   localparam int unsigned TPS_MAX_THREADS = 16;

   // Request opcodes.
   typedef enum logic [2:0] {
      OP_ADMIT    = 3'd0,
      OP_START    = 3'd1,
      OP_YIELD    = 3'd2,
      OP_BLOCK    = 3'd3,
      OP_UNBLOCK  = 3'd4,
      OP_KILL     = 3'd5,
      OP_SET_PRIO = 3'd6,
      OP_JOIN     = 3'd7
   } op_code_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NO_RUN    = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_JOINED    = 3'd3,
      STS_BAD_PRIO  = 3'd4
   } status_type;

   // Per-thread life cycle states.
   typedef enum logic [2:0] {
      THR_UNUSED   = 3'd0,
      THR_READY    = 3'd1,
      THR_RUNNING  = 3'd2,
      THR_BLOCKED  = 3'd3,
      THR_FINISHED = 3'd4
   } thr_state_type;

   // Priority levels; the level number is also the ready queue index.
   localparam logic [1:0] PRIO_HIGH = 2'd0;
   localparam logic [1:0] PRIO_MED  = 2'd1;
   localparam logic [1:0] PRIO_LOW  = 2'd2;
   localparam logic [1:0] PRIO_BAD  = 2'd3;

   // One entry of the thread table.
   typedef struct packed {
      thr_state_type st;
      logic [1:0]    prio;
   } thr_entry_type;

   localparam thr_entry_type THR_ENTRY_RESET = '{st: THR_UNUSED, prio: PRIO_LOW};

   // Write controls toward the thread table.
   typedef struct packed {
      logic          thr_we;
      thr_entry_type thr_wdata;
      logic          join_we;
      logic          join_wvalid;
   } tt_ctrl_type;

   // Push and pop controls toward the ready queues.
   typedef struct packed {
      logic       push;
      logic [1:0] push_lvl;
      logic       pop;
   } rq_ctrl_type;

   // Occupancy summary from the ready queues.
   typedef struct packed {
      logic       any;
      logic [1:0] lvl;
   } rq_stat_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_WAKE,
      S_POP,
      S_LOAD,
      S_FINISH
   } seq_state_type;

endpackage

// ===== design/tps_ram.sv =====
// ----------------------------------------------------------------------------
// tps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tps_ready_queues.sv =====
// ----------------------------------------------------------------------------
// tps_ready_queues
// Three circular FIFO ready queues, one per priority level, kept in one RAM.
// ----------------------------------------------------------------------------
module tps_ready_queues
   import tps_pkg::*;
#(
   parameter int unsigned MAX_THREADS = TPS_MAX_THREADS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rq_ctrl_type                    ctrl,
   input  logic [$clog2(MAX_THREADS)-1:0] push_tid,
   output rq_stat_type                    stat,
   output logic [$clog2(MAX_THREADS)-1:0] pop_tid,
   output logic [1:0]                     pop_lvl
);

   localparam int TID_W = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam int RAM_DEPTH = 3 * (2 ** TID_W);

   logic [TID_W-1:0] head_ff [3];
   logic [TID_W-1:0] head_in [3];
   logic [TID_W-1:0] tail_ff [3];
   logic [TID_W-1:0] tail_in [3];
   logic [CNT_W-1:0] count_ff [3];
   logic [CNT_W-1:0] count_in [3];
   logic [1:0]       pop_lvl_ff;
   logic [1:0]       pop_lvl_in;
   logic             push_ok;
   logic             do_push;
   logic             do_pop;

   function automatic logic [TID_W-1:0] wrap_inc(input logic [TID_W-1:0] v);
      return (v == TID_W'(MAX_THREADS - 1)) ? '0 : v + 1'b1;
   endfunction

   always_comb begin
      stat.any = (count_ff[0] != '0) || (count_ff[1] != '0) || (count_ff[2] != '0);
      if (count_ff[0] != '0) begin
         stat.lvl = PRIO_HIGH;
      end else if (count_ff[1] != '0) begin
         stat.lvl = PRIO_MED;
      end else begin
         stat.lvl = PRIO_LOW;
      end
   end

   // A full level drops the push, the thread stays marked ready.
   assign push_ok = count_ff[ctrl.push_lvl] < CNT_W'(MAX_THREADS);

   always_comb begin
      pop_lvl_in = ctrl.pop ? stat.lvl : pop_lvl_ff;
      do_push    = 1'b0;
      do_pop     = 1'b0;
      for (int l = 0; l < 3; l++) begin
         do_push     = ctrl.push && push_ok && (ctrl.push_lvl == 2'(l));
         do_pop      = ctrl.pop && stat.any && (stat.lvl == 2'(l));
         head_in[l]  = do_pop ? wrap_inc(head_ff[l]) : head_ff[l];
         tail_in[l]  = do_push ? wrap_inc(tail_ff[l]) : tail_ff[l];
         count_in[l] = count_ff[l];
         if (do_push && !do_pop) begin
            count_in[l] = count_ff[l] + 1'b1;
         end else if (do_pop && !do_push) begin
            count_in[l] = count_ff[l] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 3; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_lvl_ff <= pop_lvl_in;
   end

   tps_ram #(
      .WIDTH (TID_W),
      .DEPTH (RAM_DEPTH)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (ctrl.push && push_ok),
      .wr_addr ({ctrl.push_lvl, tail_ff[ctrl.push_lvl]}),
      .wr_data (push_tid),
      .rd_addr ({stat.lvl, head_ff[stat.lvl]}),
      .rd_data (pop_tid)
   );

   assign pop_lvl = pop_lvl_ff;

endmodule

// ===== design/tps_thread_table.sv =====
// ----------------------------------------------------------------------------
// tps_thread_table
// Per-thread state, priority and join waiter, held in RAMs with valid bits
// so that untouched entries read as their reset values.
// ----------------------------------------------------------------------------
module tps_thread_table
   import tps_pkg::*;
#(
   parameter int unsigned MAX_THREADS = TPS_MAX_THREADS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tt_ctrl_type                    ctrl,
   input  logic [$clog2(MAX_THREADS)-1:0] thr_waddr,
   input  logic [$clog2(MAX_THREADS)-1:0] thr_raddr,
   input  logic [$clog2(MAX_THREADS)-1:0] join_waddr,
   input  logic [$clog2(MAX_THREADS)-1:0] join_raddr,
   input  logic [$clog2(MAX_THREADS)-1:0] join_wtid,
   output thr_entry_type                  thr_rdata,
   output logic                           join_rvalid,
   output logic [$clog2(MAX_THREADS)-1:0] join_rtid
);

   localparam int TID_W = $clog2(MAX_THREADS);
   localparam int THR_W = $bits(thr_entry_type);

   logic [MAX_THREADS-1:0] thr_vld_ff;
   logic [MAX_THREADS-1:0] join_vld_ff;
   logic                   thr_vld_q_ff;
   logic                   join_vld_q_ff;
   logic [THR_W-1:0]       thr_ram_q;
   logic [TID_W:0]         join_ram_q;
   logic [TID_W:0]         join_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_vld_ff    <= '0;
         join_vld_ff   <= '0;
         thr_vld_q_ff  <= 1'b0;
         join_vld_q_ff <= 1'b0;
      end else begin
         if (ctrl.thr_we) begin
            thr_vld_ff[thr_waddr] <= 1'b1;
         end
         if (ctrl.join_we) begin
            join_vld_ff[join_waddr] <= 1'b1;
         end
         thr_vld_q_ff  <= thr_vld_ff[thr_raddr];
         join_vld_q_ff <= join_vld_ff[join_raddr];
      end
   end

   tps_ram #(
      .WIDTH (THR_W),
      .DEPTH (MAX_THREADS)
   ) u_thr_ram (
      .clock   (clock),
      .wr_en   (ctrl.thr_we),
      .wr_addr (thr_waddr),
      .wr_data (ctrl.thr_wdata),
      .rd_addr (thr_raddr),
      .rd_data (thr_ram_q)
   );

   tps_ram #(
      .WIDTH (TID_W + 1),
      .DEPTH (MAX_THREADS)
   ) u_join_ram (
      .clock   (clock),
      .wr_en   (ctrl.join_we),
      .wr_addr (join_waddr),
      .wr_data ({ctrl.join_wvalid, join_wtid}),
      .rd_addr (join_raddr),
      .rd_data (join_ram_q)
   );

   assign thr_rdata   = thr_vld_q_ff ? thr_entry_type'(thr_ram_q) : THR_ENTRY_RESET;
   assign join_q      = join_vld_q_ff ? join_ram_q : '0;
   assign join_rvalid = join_q[TID_W];
   assign join_rtid   = join_q[TID_W-1:0];

endmodule

// ===== design/three_level_priority_thread_scheduler.sv =====
// Sequence: a taken request is evaluated in S_EVAL. One that takes the running thread out
// goes on through S_POP, and S_LOAD when a new thread is picked, with S_WAKE first for a
// join waiter. S_FINISH registers the result. One request at a time: req_ready returns as
// the result is loaded, later while an earlier result is still unclaimed.
// Reset (synchronous, active high) leaves no thread running, all threads unused at low
// priority, empty ready queues and an empty join table, with no clearing pass.
// ----------------------------------------------------------------------------
// three_level_priority_thread_scheduler
// Strict-priority thread scheduler with one running slot, three FIFO ready
// levels, a blocked set and a per-thread join waiter, run by a small sequencer.
// ----------------------------------------------------------------------------
module three_level_priority_thread_scheduler
   import tps_pkg::*;
#(
   parameter int unsigned MAX_THREADS = TPS_MAX_THREADS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_opcode,
   input  logic [3:0] req_target_tid,
   input  logic [1:0] req_priority_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic       rsp_running_valid,
   output logic [3:0] rsp_running_tid,
   output logic [1:0] rsp_running_prio
);

   localparam int TID_W = $clog2(MAX_THREADS);

   // Sequencer and request registers.
   seq_state_type    state_ff, state_in;
   op_code_type      op_ff, op_in;
   logic [3:0]       tid_ff, tid_in;
   logic [1:0]       prio_ff, prio_in;
   status_type       status_ff, status_in;
   logic [TID_W-1:0] waiter_ff, waiter_in;

   // Running slot. The running thread's priority is shadowed here so the
   // result never needs a table read.
   logic             run_valid_ff, run_valid_in;
   logic [TID_W-1:0] run_tid_ff, run_tid_in;
   logic [1:0]       run_prio_ff, run_prio_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_run_valid_ff, rsp_run_valid_in;
   logic [3:0]       rsp_run_tid_ff, rsp_run_tid_in;
   logic [1:0]       rsp_run_prio_ff, rsp_run_prio_in;

   // Thread table and ready queue hookup.
   tt_ctrl_type      tt_ctrl;
   logic [TID_W-1:0] thr_waddr, thr_raddr, join_waddr, join_raddr;
   thr_entry_type    tgt;
   logic             join_rvalid;
   logic [TID_W-1:0] join_rtid;
   rq_ctrl_type      rq_ctrl;
   rq_stat_type      rq_stat;
   logic [TID_W-1:0] push_tid, pop_tid;
   logic [1:0]       pop_lvl;

   logic [TID_W-1:0] tid_idx;
   logic [TID_W-1:0] req_idx;
   logic             tid_ok;
   logic             tgt_free;

   assign tid_idx  = TID_W'(tid_ff);
   assign req_idx  = TID_W'(req_target_tid);
   assign tid_ok   = 32'(tid_ff) < 32'(MAX_THREADS);
   assign tgt_free = (tgt.st == THR_UNUSED) || (tgt.st == THR_FINISHED);

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_valid_ff <= 1'b0;
         run_tid_ff   <= '0;
         run_prio_ff  <= PRIO_HIGH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         run_tid_ff   <= run_tid_in;
         run_prio_ff  <= run_prio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      tid_ff          <= tid_in;
      prio_ff         <= prio_in;
      status_ff       <= status_in;
      waiter_ff       <= waiter_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_run_valid_ff <= rsp_run_valid_in;
      rsp_run_tid_ff  <= rsp_run_tid_in;
      rsp_run_prio_ff <= rsp_run_prio_in;
   end

   // The sequencer. A request is evaluated in S_EVAL against the table entry
   // of its target (read while it was taken in S_IDLE). Requests that take
   // the running thread out of the slot then go through S_POP, which pops
   // the head of the highest non-empty level, and S_LOAD, which marks the
   // popped thread running. A queued thread always sits in the level equal
   // to its priority, so the level it came from is its priority. A kill
   // whose thread has a join waiter takes a detour through S_WAKE to look at
   // the waiter and requeue it if it is still blocked.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      tid_in      = tid_ff;
      prio_in     = prio_ff;
      status_in   = status_ff;
      waiter_in   = waiter_ff;
      run_valid_in = run_valid_ff;
      run_tid_in  = run_tid_ff;
      run_prio_in = run_prio_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_run_valid_in = rsp_run_valid_ff;
      rsp_run_tid_in   = rsp_run_tid_ff;
      rsp_run_prio_in  = rsp_run_prio_ff;

      tt_ctrl    = '0;
      thr_waddr  = run_tid_ff;
      thr_raddr  = req_idx;
      join_raddr = (req_opcode == OP_KILL) ? run_tid_ff : req_idx;
      join_waddr = (op_ff == OP_KILL) ? run_tid_ff : tid_idx;
      rq_ctrl    = '0;
      push_tid   = run_tid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = op_code_type'(req_opcode);
               tid_in    = req_target_tid;
               prio_in   = req_priority_req;
               status_in = STS_OK;
               state_in  = S_EVAL;
            end
         end

         S_EVAL: begin
            // For a kill, this fetches the waiter's table entry for S_WAKE.
            thr_raddr = join_rtid;
            state_in  = S_FINISH;
            unique case (op_ff)
               OP_ADMIT: begin
                  if (prio_ff == PRIO_BAD) begin
                     status_in = STS_BAD_PRIO;
                  end else if (!tid_ok || !tgt_free) begin
                     status_in = STS_NOT_FOUND;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_READY, prio: prio_ff};
                     thr_waddr         = tid_idx;
                     tt_ctrl.join_we   = 1'b1;
                     rq_ctrl.push      = 1'b1;
                     rq_ctrl.push_lvl  = prio_ff;
                     push_tid          = tid_idx;
                  end
               end
               OP_START: begin
                  if (run_valid_ff || !tid_ok || !tgt_free) begin
                     status_in = STS_NOT_FOUND;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_RUNNING, prio: PRIO_LOW};
                     thr_waddr         = tid_idx;
                     tt_ctrl.join_we   = 1'b1;
                     run_valid_in      = 1'b1;
                     run_tid_in        = tid_idx;
                     run_prio_in       = PRIO_LOW;
                  end
               end
               OP_YIELD: begin
                  if (!run_valid_ff) begin
                     status_in = STS_NO_RUN;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_READY, prio: run_prio_ff};
                     rq_ctrl.push      = 1'b1;
                     rq_ctrl.push_lvl  = run_prio_ff;
                     state_in          = S_POP;
                  end
               end
               OP_BLOCK: begin
                  if (!run_valid_ff) begin
                     status_in = STS_NO_RUN;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_BLOCKED, prio: run_prio_ff};
                     state_in          = S_POP;
                  end
               end
               OP_UNBLOCK: begin
                  if (!tid_ok || tgt.st != THR_BLOCKED) begin
                     status_in = STS_NOT_FOUND;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_READY, prio: tgt.prio};
                     thr_waddr         = tid_idx;
                     rq_ctrl.push      = 1'b1;
                     rq_ctrl.push_lvl  = tgt.prio;
                     push_tid          = tid_idx;
                  end
               end
               OP_KILL: begin
                  if (!run_valid_ff) begin
                     status_in = STS_NO_RUN;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_FINISHED, prio: run_prio_ff};
                     if (join_rvalid) begin
                        tt_ctrl.join_we = 1'b1;
                        waiter_in       = join_rtid;
                        state_in        = S_WAKE;
                     end else begin
                        state_in = S_POP;
                     end
                  end
               end
               OP_SET_PRIO: begin
                  if (!run_valid_ff) begin
                     status_in = STS_NO_RUN;
                  end else if (prio_ff == PRIO_BAD) begin
                     status_in = STS_BAD_PRIO;
                  end else begin
                     tt_ctrl.thr_we    = 1'b1;
                     tt_ctrl.thr_wdata = '{st: THR_RUNNING, prio: prio_ff};
                     run_prio_in       = prio_ff;
                  end
               end
               OP_JOIN: begin
                  if (!run_valid_ff) begin
                     status_in = STS_NO_RUN;
                  end else if (!tid_ok || tgt.st != THR_READY) begin
                     status_in = STS_NOT_FOUND;
                  end else if (join_rvalid) begin
                     status_in = STS_JOINED;
                  end else begin
                     tt_ctrl.join_we     = 1'b1;
                     tt_ctrl.join_wvalid = 1'b1;
                     tt_ctrl.thr_we      = 1'b1;
                     tt_ctrl.thr_wdata   = '{st: THR_BLOCKED, prio: run_prio_ff};
                     state_in            = S_POP;
                  end
               end
               default: begin
                  status_in = STS_OK;
               end
            endcase
         end

         S_WAKE: begin
            // The waiter's entry was fetched in S_EVAL; only a still blocked
            // waiter goes back to its ready level.
            if (tgt.st == THR_BLOCKED) begin
               tt_ctrl.thr_we    = 1'b1;
               tt_ctrl.thr_wdata = '{st: THR_READY, prio: tgt.prio};
               thr_waddr         = waiter_ff;
               rq_ctrl.push      = 1'b1;
               rq_ctrl.push_lvl  = tgt.prio;
               push_tid          = waiter_ff;
            end
            state_in = S_POP;
         end

         S_POP: begin
            if (rq_stat.any) begin
               rq_ctrl.pop = 1'b1;
               state_in    = S_LOAD;
            end else begin
               run_valid_in = 1'b0;
               run_tid_in   = '0;
               run_prio_in  = PRIO_HIGH;
               state_in     = S_FINISH;
            end
         end

         S_LOAD: begin
            tt_ctrl.thr_we    = 1'b1;
            tt_ctrl.thr_wdata = '{st: THR_RUNNING, prio: pop_lvl};
            thr_waddr         = pop_tid;
            run_valid_in      = 1'b1;
            run_tid_in        = pop_tid;
            run_prio_in       = pop_lvl;
            state_in          = S_FINISH;
         end

         S_FINISH: begin
            // Wait here only while an earlier result is still unclaimed.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_run_valid_in = run_valid_ff;
               rsp_run_tid_in   = run_valid_ff ? 4'(run_tid_ff) : 4'd0;
               rsp_run_prio_in  = run_valid_ff ? run_prio_ff : 2'd0;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   tps_thread_table #(
      .MAX_THREADS (MAX_THREADS)
   ) u_thread_table (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tt_ctrl),
      .thr_waddr   (thr_waddr),
      .thr_raddr   (thr_raddr),
      .join_waddr  (join_waddr),
      .join_raddr  (join_raddr),
      .join_wtid   (run_tid_ff),
      .thr_rdata   (tgt),
      .join_rvalid (join_rvalid),
      .join_rtid   (join_rtid)
   );

   tps_ready_queues #(
      .MAX_THREADS (MAX_THREADS)
   ) u_ready_queues (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rq_ctrl),
      .push_tid (push_tid),
      .stat     (rq_stat),
      .pop_tid  (pop_tid),
      .pop_lvl  (pop_lvl)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_running_valid = rsp_run_valid_ff;
   assign rsp_running_tid   = rsp_run_tid_ff;
   assign rsp_running_prio  = rsp_run_prio_ff;

endmodule

// ===== design/tps_checker.sv =====
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tps_checker
   import tps_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_opcode,
   input logic [3:0] req_target_tid,
   input logic [1:0] req_priority_req,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic       rsp_running_valid,
   input logic [3:0] rsp_running_tid,
   input logic [1:0] rsp_running_prio
);

   // An idle running slot reports zero id and priority.
   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> rsp_running_tid == 4'd0 && rsp_running_prio == 2'd0)
      else $error("idle running slot reports nonzero id or priority");

   // The running thread never carries the invalid priority, and status is a known code.
   a_result_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_prio != PRIO_BAD && rsp_status <= STS_BAD_PRIO)
      else $error("result carries an undefined priority or status code");

   // A taken request keeps the scheduler busy in the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is still being evaluated");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_running_valid) && $stable(rsp_running_tid)
         && $stable(rsp_running_prio))
      else $error("stalled result changed before its transfer");

endmodule

bind three_level_priority_thread_scheduler tps_checker u_tps_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level priority thread scheduler. A short
// table of directed requests is followed by random request streams shaped by
// the current thread states; every result is compared with a fixed row result
// or an in-bench model of the scheduler under changing sender and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import tps_pkg::*;

   // One result as the scheduler reports it.
   typedef struct packed {
      status_type status;
      logic       run_valid;
      logic [3:0] run_tid;
      logic [1:0] run_prio;
   } sched_result_type;

   // One row of the directed table. Rows with has_fixed set carry a result
   // that is plain from the request alone; the others are predicted.
   typedef struct packed {
      op_code_type      op;
      logic [3:0]       tid;
      logic [1:0]       prio;
      logic             has_fixed;
      sched_result_type fixed;
   } directed_row_type;

   localparam int unsigned NUM_THREADS  = TPS_MAX_THREADS;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 10;

   localparam sched_result_type NOTHING_RUNS = '{STS_NO_RUN, 1'b0, 4'd0, 2'd0};
   localparam sched_result_type PREDICTED    = '0;

   // The directed walk: every opcode but start refused with nothing running, the
   // bad priority paths, a start that ignores its priority, admits at every level,
   // a join, a join on an already joined target, a yield that gets the same
   // thread back, kills that wake their joined waiters, and a block that
   // leaves the running slot empty, then an unblock and a start.
   localparam int unsigned NUM_DIRECTED = 25;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{OP_YIELD,    4'd0,  PRIO_HIGH, 1'b1, NOTHING_RUNS},
      '{OP_BLOCK,    4'd0,  PRIO_HIGH, 1'b1, NOTHING_RUNS},
      '{OP_KILL,     4'd0,  PRIO_HIGH, 1'b1, NOTHING_RUNS},
      '{OP_SET_PRIO, 4'd0,  PRIO_HIGH, 1'b1, NOTHING_RUNS},
      '{OP_JOIN,     4'd3,  PRIO_HIGH, 1'b1, NOTHING_RUNS},
      '{OP_UNBLOCK,  4'd5,  PRIO_HIGH, 1'b1, '{STS_NOT_FOUND, 1'b0, 4'd0, 2'd0}},
      '{OP_ADMIT,    4'd0,  PRIO_BAD,  1'b1, '{STS_BAD_PRIO, 1'b0, 4'd0, 2'd0}},
      '{OP_START,    4'd15, PRIO_HIGH, 1'b1, '{STS_OK, 1'b1, 4'd15, PRIO_LOW}},
      '{OP_START,    4'd1,  PRIO_HIGH, 1'b1, '{STS_NOT_FOUND, 1'b1, 4'd15, PRIO_LOW}},
      '{OP_SET_PRIO, 4'd0,  PRIO_BAD,  1'b1, '{STS_BAD_PRIO, 1'b1, 4'd15, PRIO_LOW}},
      '{OP_SET_PRIO, 4'd0,  PRIO_HIGH, 1'b1, '{STS_OK, 1'b1, 4'd15, PRIO_HIGH}},
      '{OP_ADMIT,    4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_ADMIT,    4'd1,  PRIO_MED,  1'b0, PREDICTED},
      '{OP_ADMIT,    4'd2,  PRIO_LOW,  1'b0, PREDICTED},
      '{OP_ADMIT,    4'd0,  PRIO_MED,  1'b0, PREDICTED},
      '{OP_JOIN,     4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_JOIN,     4'd2,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_JOIN,     4'd2,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_YIELD,    4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_KILL,     4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_KILL,     4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_KILL,     4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_BLOCK,    4'd0,  PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_UNBLOCK,  4'd15, PRIO_HIGH, 1'b0, PREDICTED},
      '{OP_START,    4'd3,  PRIO_MED,  1'b0, PREDICTED}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_opcode;
   logic [3:0] req_target_tid;
   logic [1:0] req_priority_req;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_status;
   logic       rsp_running_valid;
   logic [3:0] rsp_running_tid;
   logic [1:0] rsp_running_prio;

   three_level_priority_thread_scheduler dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_target_tid    (req_target_tid),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_tid   (rsp_running_tid),
      .rsp_running_prio  (rsp_running_prio)
   );

   // ------------------------------------------------------------------------
   // Scheduler model. It mirrors the thread table, the three ready FIFOs, the
   // running slot and the join table, and is advanced once per request
   // transfer, in transfer order.
   // ------------------------------------------------------------------------
   thr_state_type thr_st    [NUM_THREADS];
   logic [1:0]    thr_prio  [NUM_THREADS];
   logic [3:0]    fifo_mem  [3][NUM_THREADS];
   logic [3:0]    fifo_head [3];
   logic [3:0]    fifo_tail [3];
   logic [4:0]    fifo_cnt  [3];
   logic          run_valid;
   logic [3:0]    run_tid;
   logic          join_valid [NUM_THREADS];
   logic [3:0]    join_tid   [NUM_THREADS];

   // Results still owed by the scheduler, oldest first.
   sched_result_type pending_results [$];

   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned results_checked;
   int unsigned status_seen [5];

   // Percent of cycles in which the sender holds off and the receiver stalls.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned quiet_cycles;

   function automatic void clear_model();
      for (int i = 0; i < NUM_THREADS; i++) begin
         thr_st[i]     = THR_UNUSED;
         thr_prio[i]   = PRIO_LOW;
         join_valid[i] = 1'b0;
         join_tid[i]   = '0;
      end
      for (int l = 0; l < 3; l++) begin
         fifo_head[l] = '0;
         fifo_tail[l] = '0;
         fifo_cnt[l]  = '0;
      end
      run_valid = 1'b0;
      run_tid   = '0;
   endfunction

   // Mark a thread ready and append it to the FIFO of its current priority.
   function automatic void make_ready(logic [3:0] t);
      int unsigned lvl;
      lvl = (thr_prio[t] > PRIO_LOW) ? PRIO_LOW : thr_prio[t];
      thr_st[t] = THR_READY;
      if (fifo_cnt[lvl] < NUM_THREADS) begin
         fifo_mem[lvl][fifo_tail[lvl]] = t;
         fifo_tail[lvl] = fifo_tail[lvl] + 4'd1;
         fifo_cnt[lvl]  = fifo_cnt[lvl] + 5'd1;
      end
   endfunction

   // Move the head of the highest non-empty level into the running slot.
   function automatic void dispatch_next();
      for (int l = 0; l < 3; l++) begin
         if (fifo_cnt[l] != 0) begin
            run_tid   = fifo_mem[l][fifo_head[l]];
            run_valid = 1'b1;
            fifo_head[l] = fifo_head[l] + 4'd1;
            fifo_cnt[l]  = fifo_cnt[l] - 5'd1;
            thr_st[run_tid] = THR_RUNNING;
            return;
         end
      end
      run_valid = 1'b0;
      run_tid   = '0;
   endfunction

   function automatic logic is_free(logic [3:0] t);
      return thr_st[t] == THR_UNUSED || thr_st[t] == THR_FINISHED;
   endfunction

   // Apply one request to the model and return the result it must produce.
   function automatic sched_result_type schedule_request(op_code_type op, logic [3:0] tid,
                                                         logic [1:0] prio);
      sched_result_type res;
      logic [3:0]       me;
      logic [3:0]       waiter;
      res.status = STS_OK;
      case (op)
         OP_ADMIT: begin
            if (prio == PRIO_BAD) res.status = STS_BAD_PRIO;
            else if (!is_free(tid)) res.status = STS_NOT_FOUND;
            else begin
               thr_prio[tid]   = prio;
               join_valid[tid] = 1'b0;
               make_ready(tid);
            end
         end
         OP_START: begin
            // A start always runs at low priority, whatever it asks for.
            if (run_valid || !is_free(tid)) res.status = STS_NOT_FOUND;
            else begin
               thr_prio[tid]   = PRIO_LOW;
               join_valid[tid] = 1'b0;
               thr_st[tid]     = THR_RUNNING;
               run_valid       = 1'b1;
               run_tid         = tid;
            end
         end
         OP_YIELD: begin
            if (!run_valid) res.status = STS_NO_RUN;
            else begin
               make_ready(run_tid);
               dispatch_next();
            end
         end
         OP_BLOCK: begin
            if (!run_valid) res.status = STS_NO_RUN;
            else begin
               thr_st[run_tid] = THR_BLOCKED;
               dispatch_next();
            end
         end
         OP_UNBLOCK: begin
            if (thr_st[tid] != THR_BLOCKED) res.status = STS_NOT_FOUND;
            else make_ready(tid);
         end
         OP_KILL: begin
            if (!run_valid) res.status = STS_NO_RUN;
            else begin
               // The joined waiter is woken only if it is still blocked.
               me = run_tid;
               thr_st[me] = THR_FINISHED;
               if (join_valid[me]) begin
                  waiter = join_tid[me];
                  join_valid[me] = 1'b0;
                  if (thr_st[waiter] == THR_BLOCKED) make_ready(waiter);
               end
               dispatch_next();
            end
         end
         OP_SET_PRIO: begin
            if (!run_valid) res.status = STS_NO_RUN;
            else if (prio == PRIO_BAD) res.status = STS_BAD_PRIO;
            else thr_prio[run_tid] = prio;
         end
         default: begin
            if (!run_valid) res.status = STS_NO_RUN;
            else if (thr_st[tid] != THR_READY) res.status = STS_NOT_FOUND;
            else if (join_valid[tid]) res.status = STS_JOINED;
            else begin
               join_valid[tid] = 1'b1;
               join_tid[tid]   = run_tid;
               thr_st[run_tid] = THR_BLOCKED;
               dispatch_next();
            end
         end
      endcase
      res.run_valid = run_valid;
      res.run_tid   = run_valid ? run_tid : 4'd0;
      res.run_prio  = run_valid ? thr_prio[run_tid] : 2'd0;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Random request planning. Most requests aim at a thread in the state that
   // lets the request succeed, so that joins, wakeups and FIFO wrapping are
   // reached; the rest are fully random noise.
   // ------------------------------------------------------------------------
   function automatic logic [3:0] find_thread(thr_state_type a, thr_state_type b);
      logic [3:0] base;
      logic [3:0] t;
      base = 4'($urandom_range(NUM_THREADS - 1));
      for (int i = 0; i < NUM_THREADS; i++) begin
         t = base + 4'(i);
         if (thr_st[t] == a || thr_st[t] == b) return t;
      end
      return 4'($urandom_range(NUM_THREADS - 1));
   endfunction

   task automatic plan_request(output op_code_type op, output logic [3:0] tid,
                               output logic [1:0] prio);
      int unsigned roll;
      int unsigned live;
      live = 0;
      for (int i = 0; i < NUM_THREADS; i++)
         if (!is_free(4'(i))) live++;
      roll = $urandom_range(99);
      prio = ($urandom_range(9) == 0) ? PRIO_BAD : 2'($urandom_range(2));
      tid  = 4'($urandom_range(NUM_THREADS - 1));
      op   = OP_YIELD;
      if (roll < 15) begin
         // Noise. Keep a few ids free so that a start can always recover an
         // empty running slot.
         op   = op_code_type'(3'($urandom_range(7)));
         prio = 2'($urandom_range(3));
         if (op == OP_ADMIT && live >= 14) tid = find_thread(THR_READY, THR_BLOCKED);
      end else if (!run_valid) begin
         case ($urandom_range(3))
            0: begin
               op  = (live < 12) ? OP_ADMIT : OP_START;
               tid = find_thread(THR_UNUSED, THR_FINISHED);
            end
            1: begin
               op  = OP_UNBLOCK;
               tid = find_thread(THR_BLOCKED, THR_BLOCKED);
            end
            default: begin
               op  = OP_START;
               tid = find_thread(THR_UNUSED, THR_FINISHED);
            end
         endcase
      end else if (live >= 12 && $urandom_range(1) == 1) begin
         op = OP_KILL;
      end else begin
         roll = $urandom_range(99);
         if (roll < 18) begin
            op  = OP_ADMIT;
            tid = (live < 12) ? find_thread(THR_UNUSED, THR_FINISHED)
                              : find_thread(THR_READY, THR_BLOCKED);
         end else if (roll < 25) begin
            op  = OP_START;
            tid = find_thread(THR_UNUSED, THR_FINISHED);
         end else if (roll < 40) op = OP_YIELD;
         else if (roll < 52) op = OP_BLOCK;
         else if (roll < 64) begin
            op  = OP_UNBLOCK;
            tid = find_thread(THR_BLOCKED, THR_BLOCKED);
         end else if (roll < 74) op = OP_KILL;
         else if (roll < 82) op = OP_SET_PRIO;
         else begin
            op  = OP_JOIN;
            tid = find_thread(THR_READY, THR_READY);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Called at a falling edge and returns at a falling edge.
   // The payload is driven at the falling edge and held until the rising edge
   // at which the transfer happens; the model is advanced at that edge.
   // ------------------------------------------------------------------------
   task automatic send_request(op_code_type op, logic [3:0] tid, logic [1:0] prio,
                               logic has_fixed, sched_result_type fixed);
      sched_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_target_tid   <= tid;
      req_priority_req <= prio;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = schedule_request(op, tid, prio);
      pending_results.push_back(has_fixed ? fixed : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // Free-running clock, period 4.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver back-pressure, redrawn at every falling edge.
   initial rsp_ready = 1'b0;
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // ------------------------------------------------------------------------
   // Result checker. Each result transfer is matched with the oldest
   // outstanding expectation, field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding: status %0d tid %0d",
                   rsp_status, rsp_running_tid);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_status < 5) status_seen[rsp_status]++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_running_valid !== want.run_valid) begin
               $error("running_valid: expected %0d, got %0d", want.run_valid,
                      rsp_running_valid);
               error_count++;
            end
            if (rsp_running_tid !== want.run_tid) begin
               $error("running_tid: expected %0d, got %0d", want.run_tid, rsp_running_tid);
               error_count++;
            end
            if (rsp_running_prio !== want.run_prio) begin
               $error("running_prio: expected %0d, got %0d", want.run_prio,
                      rsp_running_prio);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run if no transfer happens on either channel for too
   // long. The slowest correct case is the sequencer's latency stretched by
   // heavy random stalls, far below this limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed table, then three random phases with
   // different back-pressure, then drain and report.
   // ------------------------------------------------------------------------
   initial begin
      op_code_type op;
      logic [3:0]  tid;
      logic [1:0]  prio;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_ADMIT;
      req_target_tid   = '0;
      req_priority_req = PRIO_HIGH;
      quiet_cycles     = 0;
      error_count      = 0;
      requests_sent    = 0;
      results_checked  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      send_idle_pct    = 12;
      recv_stall_pct   = 85;
      clear_model();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].tid, DIRECTED_ROWS[i].prio,
                      DIRECTED_ROWS[i].has_fixed, DIRECTED_ROWS[i].fixed);

      // Phase one keeps the sender busy against a slow receiver, phase two
      // flips that, phase three runs both sides flat out.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 85;
            recv_stall_pct = 12;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         plan_request(op, tid, prio);
         send_request(op, tid, prio, 1'b0, PREDICTED);
      end
      req_valid <= 1'b0;

      // Wait for every owed result, then keep watching for strays before the report.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d directed) and checked %0d results.",
               requests_sent, NUM_DIRECTED, results_checked);
      $display("Status mix: ok %0d, no thread %0d, not found %0d, joined %0d, bad prio %0d.",
               status_seen[STS_OK], status_seen[STS_NO_RUN], status_seen[STS_NOT_FOUND],
               status_seen[STS_JOINED], status_seen[STS_BAD_PRIO]);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
